// ----- sv/lsps_pkg.sv -----
package lsps_pkg;

	localparam int SENSOR_COUNT_DEF   = 13;
	localparam int CENTER_SLOT_DEF    = 6;
	localparam int GAIN_FRAC_BITS_DEF = 10;
	localparam int INTEGRAL_BITS_DEF  = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WHITE_LINE    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN    = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_FLOOR   = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_CEILING = 3'd7;

	localparam logic [9:0]  THRESHOLD_RST     = 10'd700;
	localparam logic        WHITE_LINE_RST    = 1'b1;
	localparam logic [19:0] PROP_GAIN_RST     = 20'd2048;
	localparam logic [19:0] DERIV_GAIN_RST    = 20'd71680;
	localparam logic [19:0] INTEG_GAIN_RST    = 20'd10;
	localparam logic [7:0]  BASE_SPEED_RST    = 8'd80;
	localparam logic [7:0]  SPEED_FLOOR_RST   = 8'd50;
	localparam logic [7:0]  SPEED_CEILING_RST = 8'd120;

	localparam logic [3:0] NO_HIT = 4'd15;

	typedef struct packed {
		logic [9:0]  threshold;
		logic        white_line;
		logic [19:0] prop_gain;
		logic [19:0] deriv_gain;
		logic [19:0] integ_gain;
		logic [7:0]  base_speed;
		logic [7:0]  speed_floor;
		logic [7:0]  speed_ceiling;
	} cfg_t;

	typedef struct packed {
		logic [3:0] first_hit;
		logic [3:0] hit_count;
	} scan_sum_t;

endpackage

// ----- sv/line_sensor_pid_steering_core.sv -----
// Line-sensor PID steering core. Takes one 10-bit sensor sample per clock on the
// input stream (slot in tdata, tlast on the last sample of a scan) and returns
// one steering result per scan: line found flag, position, error, saturated
// correction and clamped left/right wheel speeds. Samples are accepted every
// cycle; a four-entry queue of scan summaries sits between the scan tracker and
// the five-stage PID pipeline, so input stalls only when the result side holds
// off long enough for four scan summaries to back up behind the stalled pipeline.
// A summary passes the queue, s1 to s4 and the output register, one result per
// cycle leaving while m_axis_tready is high. Configuration registers are written
// through cfg_we/cfg_addr/cfg_data and must only change while the core is idle.
module line_sensor_pid_steering_core
	import lsps_pkg::*;
#(
	parameter int SENSOR_COUNT   = SENSOR_COUNT_DEF,
	parameter int CENTER_SLOT    = CENTER_SLOT_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // sample[9:0], sensor_slot[13:10]
	input  logic                  s_axis_tlast,  // scan_end
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// line_position[4:0], position_error[8:5], drive_correction[24:9],
	// left_speed[32:25], right_speed[40:33]
	output logic [47:0]           m_axis_tdata,
	output logic                  m_axis_tuser   // line_found
);

	cfg_t cfg_q;

	logic      push;
	scan_sum_t push_data;
	logic      q_full;
	logic      q_pop;
	scan_sum_t q_data;
	logic      q_empty;

	logic               line_found;
	logic signed [4:0]  line_position;
	logic signed [3:0]  position_error;
	logic signed [15:0] drive_correction;
	logic [7:0]         left_speed;
	logic [7:0]         right_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= THRESHOLD_RST;
			cfg_q.white_line    <= WHITE_LINE_RST;
			cfg_q.prop_gain     <= PROP_GAIN_RST;
			cfg_q.deriv_gain    <= DERIV_GAIN_RST;
			cfg_q.integ_gain    <= INTEG_GAIN_RST;
			cfg_q.base_speed    <= BASE_SPEED_RST;
			cfg_q.speed_floor   <= SPEED_FLOOR_RST;
			cfg_q.speed_ceiling <= SPEED_CEILING_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_THRESHOLD:     cfg_q.threshold     <= cfg_data[9:0];
				REG_WHITE_LINE:    cfg_q.white_line    <= cfg_data[0];
				REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data;
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_data;
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_data;
				REG_BASE_SPEED:    cfg_q.base_speed    <= cfg_data[7:0];
				REG_SPEED_FLOOR:   cfg_q.speed_floor   <= cfg_data[7:0];
				REG_SPEED_CEILING: cfg_q.speed_ceiling <= cfg_data[7:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	lsps_front #(
		.SENSOR_COUNT(SENSOR_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.sample     (s_axis_tdata[9:0]),
		.sensor_slot(s_axis_tdata[13:10]),
		.scan_end   (s_axis_tlast),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	lsps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	lsps_back #(
		.SENSOR_COUNT  (SENSOR_COUNT),
		.CENTER_SLOT   (CENTER_SLOT),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.INTEGRAL_BITS (INTEGRAL_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.line_found      (line_found),
		.line_position   (line_position),
		.position_error  (position_error),
		.drive_correction(drive_correction),
		.left_speed      (left_speed),
		.right_speed     (right_speed)
	);

	assign m_axis_tuser = line_found;
	assign m_axis_tdata = {7'd0, right_speed, left_speed, drive_correction,
	                       position_error, line_position};

endmodule

// ----- sv/lsps_queue.sv -----
module lsps_queue
	import lsps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  scan_sum_t push_data,
	output logic      full,
	input  logic      pop,
	output scan_sum_t pop_data,
	output logic      empty
);

	scan_sum_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full     = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QUEUE_AW-1:0])
		else $error("queue pointers disagree with count");
`endif

endmodule

// ----- sv/lsps_front.sv -----
module lsps_front
	import lsps_pkg::*;
#(
	parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [9:0] sample,
	input  logic [3:0] sensor_slot,
	input  logic       scan_end,
	output logic       push,
	output scan_sum_t  push_data,
	input  logic       q_full
);

	logic [3:0] first_hit_q;
	logic [3:0] hit_count_q;

	logic       accept;
	logic       hit;
	logic [3:0] first_nx;
	logic [3:0] count_nx;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hit      = (sensor_slot < 4'(SENSOR_COUNT))
	                  && ((sample <= cfg.threshold) == cfg.white_line);

	always_comb begin
		first_nx = first_hit_q;
		count_nx = hit_count_q;
		if (hit) begin
			if (hit_count_q == '0 || sensor_slot < first_hit_q) begin
				first_nx = sensor_slot;
			end
			if (hit_count_q != 4'd15) begin
				count_nx = hit_count_q + 4'd1;
			end
		end
	end

	assign push                = accept && scan_end;
	assign push_data.first_hit = first_nx;
	assign push_data.hit_count = count_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hit_q <= NO_HIT;
			hit_count_q <= '0;
		end else if (accept) begin
			if (scan_end) begin
				first_hit_q <= NO_HIT;
				hit_count_q <= '0;
			end else begin
				first_hit_q <= first_nx;
				hit_count_q <= count_nx;
			end
		end
	end

`ifndef SYNTHESIS
	a_empty_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q == '0 |-> first_hit_q == NO_HIT)
		else $error("scan tracker holds a first hit without hits");
`endif

endmodule

// ----- sv/lsps_back.sv -----
module lsps_back
	import lsps_pkg::*;
#(
	parameter int SENSOR_COUNT   = SENSOR_COUNT_DEF,
	parameter int CENTER_SLOT    = CENTER_SLOT_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_empty,
	input  scan_sum_t          q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               line_found,
	output logic signed [4:0]  line_position,
	output logic signed [3:0]  position_error,
	output logic signed [15:0] drive_correction,
	output logic [7:0]         left_speed,
	output logic [7:0]         right_speed
);

	localparam int IB    = INTEGRAL_BITS;
	localparam int P_W   = 26;
	localparam int D_W   = 28;
	localparam int I_W   = IB + 21;
	localparam int ACC_W = IB + 26;
	localparam int SH_W  = ACC_W - GAIN_FRAC_BITS;

	localparam logic [4:0]  POS_MAX = 5'(SENSOR_COUNT - 1);
	localparam logic [5:0]  CENTER  = 6'(CENTER_SLOT);
	localparam logic [ACC_W-1:0] RND = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
	localparam logic signed [IB-1:0] I_MAX = {1'b0, {(IB-1){1'b1}}};
	localparam logic signed [IB-1:0] I_MIN = {1'b1, {(IB-1){1'b0}}};
	localparam logic signed [SH_W-1:0] C_MAX = SH_W'(32767);
	localparam logic signed [SH_W-1:0] C_MIN = -SH_W'(32768);

	logic en;

	logic signed [4:0]    prev_error_q;
	logic signed [IB-1:0] integ_q;

	// s1: position, error, integral
	logic                 found_c;
	logic [4:0]           pos_raw;
	logic [4:0]           pos_c;
	logic signed [5:0]    err6;
	logic signed [4:0]    err_c;
	logic signed [6:0]    derr_c;
	logic signed [IB:0]   isum;
	logic signed [IB-1:0] integ_nx;

	logic                 v_s1, found_s1;
	logic signed [4:0]    pos_s1, err_s1;
	logic signed [6:0]    derr_s1;
	logic signed [IB-1:0] integ_s1;

	// s2: products
	logic signed [P_W-1:0] p_c;
	logic signed [D_W-1:0] d_c;
	logic signed [I_W-1:0] i_c;
	logic                  v_s2, found_s2;
	logic signed [4:0]     pos_s2, err_s2;
	logic signed [P_W-1:0] p_s2;
	logic signed [D_W-1:0] d_s2;
	logic signed [I_W-1:0] i_s2;

	// s3: sum
	logic                    v_s3, found_s3;
	logic signed [4:0]       pos_s3, err_s3;
	logic signed [ACC_W-1:0] acc_s3;

	// s4: truncate and saturate
	logic [ACC_W-1:0]       acc_adj;
	logic signed [SH_W-1:0] sh;
	logic signed [15:0]     corr_c;
	logic signed [3:0]      err_sat;
	logic                   v_s4, found_s4;
	logic signed [4:0]      pos_s4;
	logic signed [3:0]      err_s4;
	logic signed [15:0]     corr_s4;

	// output: wheel speeds
	logic signed [17:0] base_ext;
	logic signed [17:0] left_raw;
	logic signed [17:0] right_raw;
	logic [7:0]         left_c;
	logic [7:0]         right_c;

	function automatic logic [7:0] clamp_speed(logic signed [17:0] v, logic [7:0] lo,
	                                           logic [7:0] hi);
		logic [7:0] r;
		if (v > $signed({10'd0, hi})) begin
			r = hi;
		end else if (v < $signed({10'd0, lo})) begin
			r = lo;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	assign en    = !out_valid || out_ready;
	assign q_pop = en && !q_empty;

	always_comb begin
		found_c = q_data.hit_count != '0;
		pos_raw = {1'b0, q_data.first_hit} + {2'b00, q_data.hit_count[3:1]};
		if (!found_c) begin
			pos_c = 5'h1f;
		end else if (pos_raw > POS_MAX) begin
			pos_c = POS_MAX;
		end else begin
			pos_c = pos_raw;
		end
		err6   = $signed(CENTER) - $signed({pos_c[4], pos_c});
		err_c  = err6[4:0];
		derr_c = $signed({{2{err_c[4]}}, err_c}) - $signed({{2{prev_error_q[4]}}, prev_error_q});
		isum   = $signed({integ_q[IB-1], integ_q}) + $signed({{(IB-4){err_c[4]}}, err_c});
		if (!found_c) begin
			integ_nx = integ_q;
		end else if (isum[IB] != isum[IB-1]) begin
			integ_nx = isum[IB] ? I_MIN : I_MAX;
		end else begin
			integ_nx = isum[IB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_q      <= '0;
		end else if (q_pop) begin
			prev_error_q <= err_c;
			integ_q      <= integ_nx;
		end
	end

	assign p_c = $signed({1'b0, cfg.prop_gain}) * err_s1;
	assign d_c = $signed({1'b0, cfg.deriv_gain}) * derr_s1;
	assign i_c = $signed({1'b0, cfg.integ_gain}) * integ_s1;

	assign acc_adj = acc_s3 + (acc_s3[ACC_W-1] ? RND : '0);
	assign sh      = acc_adj[ACC_W-1:GAIN_FRAC_BITS];

	always_comb begin
		if (!found_s3) begin
			corr_c = '0;
		end else if (sh > C_MAX) begin
			corr_c = 16'sh7fff;
		end else if (sh < C_MIN) begin
			corr_c = 16'sh8000;
		end else begin
			corr_c = sh[15:0];
		end
		if (err_s3 > 5'sd7) begin
			err_sat = 4'sd7;
		end else if (err_s3 < -5'sd8) begin
			err_sat = -4'sd8;
		end else begin
			err_sat = err_s3[3:0];
		end
	end

	assign base_ext  = $signed({10'd0, cfg.base_speed});
	assign left_raw  = base_ext - $signed({{2{corr_s4[15]}}, corr_s4});
	assign right_raw = base_ext + $signed({{2{corr_s4[15]}}, corr_s4});
	assign left_c    = clamp_speed(left_raw, cfg.speed_floor, cfg.speed_ceiling);
	assign right_c   = clamp_speed(right_raw, cfg.speed_floor, cfg.speed_ceiling);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= q_pop;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_s1 <= found_c;
			pos_s1   <= pos_c;
			err_s1   <= err_c;
			derr_s1  <= derr_c;
			integ_s1 <= integ_nx;

			found_s2 <= found_s1;
			pos_s2   <= pos_s1;
			err_s2   <= err_s1;
			p_s2     <= p_c;
			d_s2     <= d_c;
			i_s2     <= i_c;

			found_s3 <= found_s2;
			pos_s3   <= pos_s2;
			err_s3   <= err_s2;
			acc_s3   <= ACC_W'(p_s2) + ACC_W'(d_s2) + ACC_W'(i_s2);

			found_s4 <= found_s3;
			pos_s4   <= pos_s3;
			err_s4   <= err_sat;
			corr_s4  <= corr_c;

			line_found       <= found_s4;
			line_position    <= pos_s4;
			position_error   <= err_s4;
			drive_correction <= corr_s4;
			left_speed       <= left_c;
			right_speed      <= right_c;
		end
	end

`ifndef SYNTHESIS
	a_no_line_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_found |-> drive_correction == '0 && line_position == -5'sd1)
		else $error("no-line result carries a correction or position");
	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !found_c |=> $stable(integ_q))
		else $error("integral moved on a scan without a line");
`endif

endmodule

// ----- tb/lsps_steer_checker.sv -----
`timescale 1ns / 100ps

module lsps_steer_checker
	import lsps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // sample[9:0], sensor_slot[13:10]
	input  logic                  s_axis_tlast,  // scan_end
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// line_position[4:0], position_error[8:5], drive_correction[24:9],
	// left_speed[32:25], right_speed[40:33]
	input  logic [47:0]           m_axis_tdata,
	input  logic                  m_axis_tuser,  // line_found
	output int                    fail_count,
	output int                    open_count
);

	localparam int     SLOTS     = SENSOR_COUNT_DEF;
	localparam int     CENTER    = CENTER_SLOT_DEF;
	localparam int     FRAC      = GAIN_FRAC_BITS_DEF;
	localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_BITS_DEF - 1)) - 1;

	typedef struct packed {
		logic        found;
		logic [4:0]  pos;
		logic [3:0]  err;
		logic [15:0] corr;
		logic [7:0]  left;
		logic [7:0]  right;
	} steer_t;

	cfg_t       regs;
	logic [3:0] first_hit;
	logic [3:0] hit_count;
	int         prev_err;
	longint     integ_sum;
	steer_t     steer_q[$];

	function automatic logic [7:0] clamp_pwm(longint v);
		longint hi, lo;
		hi = regs.speed_ceiling;
		lo = regs.speed_floor;
		if (v > hi) return regs.speed_ceiling;
		if (v < lo) return regs.speed_floor;
		return v[7:0];
	endfunction

	task automatic take_sample(input logic [9:0] smp, input logic [3:0] slot, input logic fin);
		steer_t res;
		int     pos, err, err4;
		longint acc, corr, kp, kd, ki, base;
		logic   found;
		if (slot < SLOTS && (smp <= regs.threshold) == regs.white_line) begin
			if (hit_count == 0 || slot < first_hit) first_hit = slot;
			if (hit_count != 4'd15) hit_count++;
		end
		if (fin) begin
			found = (hit_count != 0);
			if (found) begin
				pos = first_hit + hit_count / 2;
				if (pos > SLOTS - 1) pos = SLOTS - 1;
			end else begin
				pos = -1;
			end
			err = CENTER - pos;
			corr = 0;
			if (found) begin
				integ_sum = integ_sum + err;
				if (integ_sum > INTEG_MAX) integ_sum = INTEG_MAX;
				else if (integ_sum < -INTEG_MAX - 1) integ_sum = -INTEG_MAX - 1;
				kp = regs.prop_gain;
				kd = regs.deriv_gain;
				ki = regs.integ_gain;
				acc = kp * err + kd * (err - prev_err) + ki * integ_sum;
				corr = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
				if (corr > 32767) corr = 32767;
				else if (corr < -32768) corr = -32768;
			end
			prev_err = err;
			err4 = (err > 7) ? 7 : ((err < -8) ? -8 : err);
			base = regs.base_speed;
			res.found = found;
			res.pos   = pos[4:0];
			res.err   = err4[3:0];
			res.corr  = corr[15:0];
			res.left  = clamp_pwm(base - corr);
			res.right = clamp_pwm(base + corr);
			steer_q.push_back(res);
			first_hit = NO_HIT;
			hit_count = 4'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		steer_t want;
		if (!arst_n) begin
			regs.threshold     = THRESHOLD_RST;
			regs.white_line    = WHITE_LINE_RST;
			regs.prop_gain     = PROP_GAIN_RST;
			regs.deriv_gain    = DERIV_GAIN_RST;
			regs.integ_gain    = INTEG_GAIN_RST;
			regs.base_speed    = BASE_SPEED_RST;
			regs.speed_floor   = SPEED_FLOOR_RST;
			regs.speed_ceiling = SPEED_CEILING_RST;
			first_hit = NO_HIT;
			hit_count = 4'd0;
			prev_err  = 0;
			integ_sum = 0;
			fail_count = 0;
			steer_q.delete();
			open_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_THRESHOLD:     regs.threshold     = cfg_data[9:0];
					REG_WHITE_LINE:    regs.white_line    = cfg_data[0];
					REG_PROP_GAIN:     regs.prop_gain     = cfg_data[19:0];
					REG_DERIV_GAIN:    regs.deriv_gain    = cfg_data[19:0];
					REG_INTEG_GAIN:    regs.integ_gain    = cfg_data[19:0];
					REG_BASE_SPEED:    regs.base_speed    = cfg_data[7:0];
					REG_SPEED_FLOOR:   regs.speed_floor   = cfg_data[7:0];
					REG_SPEED_CEILING: regs.speed_ceiling = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (steer_q.size() == 0) begin
					$error("result with no scan pending: tuser %b tdata %h",
						m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = steer_q.pop_front();
					if (m_axis_tuser !== want.found) begin
						$error("line_found: expected %0d, got %0d", want.found, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tdata[4:0] !== want.pos) begin
						$error("line_position: expected %0d, got %0d",
							$signed(want.pos), $signed(m_axis_tdata[4:0]));
						fail_count++;
					end
					if (m_axis_tdata[8:5] !== want.err) begin
						$error("position_error: expected %0d, got %0d",
							$signed(want.err), $signed(m_axis_tdata[8:5]));
						fail_count++;
					end
					if (m_axis_tdata[24:9] !== want.corr) begin
						$error("drive_correction: expected %0d, got %0d",
							$signed(want.corr), $signed(m_axis_tdata[24:9]));
						fail_count++;
					end
					if (m_axis_tdata[32:25] !== want.left) begin
						$error("left_speed: expected %0d, got %0d",
							want.left, m_axis_tdata[32:25]);
						fail_count++;
					end
					if (m_axis_tdata[40:33] !== want.right) begin
						$error("right_speed: expected %0d, got %0d",
							want.right, m_axis_tdata[40:33]);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_sample(s_axis_tdata[9:0], s_axis_tdata[13:10], s_axis_tlast);
			open_count <= steer_q.size();
		end
	end

endmodule

// ----- tb/tb_line_sensor_pid_steering_core.sv -----
`timescale 1ns / 100ps

module tb_line_sensor_pid_steering_core;
	import lsps_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE      = 12;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 135;
	localparam int HOLD_CYCLES = 1000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;   // sample[9:0], sensor_slot[13:10]
	logic                  s_axis_tlast;   // scan_end
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// line_position[4:0], position_error[8:5], drive_correction[24:9],
	// left_speed[32:25], right_speed[40:33]
	logic [47:0]           m_axis_tdata;
	logic                  m_axis_tuser;   // line_found

	int         fail_count;
	int         open_count;
	int         cycles = 0;
	int         sent_items = 0;
	logic [9:0] thr_now;
	logic       white_now;
	bit         calm_send;
	bit         calm_recv;

	line_sensor_pid_steering_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lsps_steer_checker u_steer_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.open_count    (open_count)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input logic [9:0] smp, input logic [3:0] slot, input logic fin);
		int gap;
		gap = calm_send ? 0 : $urandom_range(6, 0);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, slot, smp};
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	// sample that reads as line colour (or not) under the current threshold
	function automatic logic [9:0] line_sample(bit want_hit);
		logic [9:0] v;
		bit         low;
		bit         edge_case;
		low = (want_hit == white_now);
		edge_case = ($urandom_range(7, 0) == 0);
		if (low) begin
			v = edge_case ? thr_now : 10'($urandom_range(thr_now, 0));
		end else if (thr_now == 10'd1023) begin
			v = 10'($urandom_range(1023, 0));
		end else begin
			v = edge_case ? thr_now + 10'd1 : 10'($urandom_range(1023, thr_now + 1));
		end
		return v;
	endfunction

	task automatic send_scan();
		int kind, width, left_edge, len;
		kind = $urandom_range(9, 0);
		calm_send = ($urandom_range(3, 0) == 0);
		if (kind < 7) begin
			// full sweep, line a few sensors wide (width 0: no line)
			width = $urandom_range(4, 0);
			left_edge = $urandom_range(SENSOR_COUNT_DEF - 1, 0);
			for (int s = 0; s < SENSOR_COUNT_DEF; s++)
				send_item(line_sample(s >= left_edge && s < left_edge + width), s[3:0],
					s == SENSOR_COUNT_DEF - 1);
		end else if (kind < 9) begin
			len = $urandom_range(20, 1);
			for (int n = 0; n < len; n++)
				send_item(10'($urandom_range(1023, 0)), 4'($urandom_range(15, 0)),
					n == len - 1);
		end else begin
			// enough hits to saturate the count
			len = $urandom_range(20, 15);
			for (int n = 0; n < len; n++)
				send_item(line_sample(1'b1), 4'($urandom_range(SENSOR_COUNT_DEF - 1, 0)),
					n == len - 1);
		end
	endtask

	task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input int phase);
		logic [CFG_DATA_W-1:0] thr, white, kp, kd, ki, base, floor_v, ceil_v;
		thr     = CFG_DATA_W'($urandom_range(1023, 0));
		white   = CFG_DATA_W'($urandom_range(1, 0));
		kp      = CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(20'hFFFFF, 0)
		                                                   : $urandom_range(16384, 0));
		kd      = CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(20'hFFFFF, 0)
		                                                   : $urandom_range(16384, 0));
		ki      = CFG_DATA_W'(($urandom_range(3, 0) == 0) ? $urandom_range(20'hFFFFF, 0)
		                                                   : $urandom_range(16384, 0));
		base    = CFG_DATA_W'($urandom_range(255, 0));
		floor_v = CFG_DATA_W'($urandom_range(127, 0));
		ceil_v  = CFG_DATA_W'($urandom_range(255, 128));
		case (phase)
			0: begin
				thr = 1023; white = 1; kp = 0; kd = 0; ki = 0;
				base = 0; floor_v = 0; ceil_v = 255;
			end
			1: begin
				thr = 0; white = 0; kp = 20'hFFFFF; kd = 20'hFFFFF; ki = 20'hFFFFF;
				base = 255; floor_v = 255; ceil_v = 255;
			end
			2: begin
				floor_v = 200; ceil_v = 30;
			end
			default: ;
		endcase
		put_reg(REG_THRESHOLD, thr);
		put_reg(REG_WHITE_LINE, white);
		put_reg(REG_PROP_GAIN, kp);
		put_reg(REG_DERIV_GAIN, kd);
		put_reg(REG_INTEG_GAIN, ki);
		put_reg(REG_BASE_SPEED, base);
		put_reg(REG_SPEED_FLOOR, floor_v);
		put_reg(REG_SPEED_CEILING, ceil_v);
		cfg_we <= 1'b0;
		thr_now   = thr[9:0];
		white_now = white[0];
	endtask

	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side: random stalls, calm stretches, two long hold-offs
	initial begin
		int stall, taken;
		taken = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 16 == 0) calm_recv = ($urandom_range(2, 0) == 0);
			if (taken == 30 || taken == 90) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = calm_recv ? 0 : $urandom_range(6, 0);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	initial begin
		int stop_at;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_addr      <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		thr_now   = THRESHOLD_RST;
		white_now = WHITE_LINE_RST;
		calm_send = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		send_item(10'd0, 4'd0, 1'b1);       // single hit at slot 0
		send_item(10'd1023, 4'd12, 1'b1);   // no line
		send_item(10'd0, 4'd15, 1'b1);      // slot out of range never hits
		send_item(10'd700, 4'd5, 1'b0);     // at threshold: hit
		send_item(10'd701, 4'd6, 1'b0);     // just above: miss
		send_item(10'd700, 4'd3, 1'b1);
		send_item(10'd0, 4'd12, 1'b0);      // repeated slot, position saturates
		send_item(10'd0, 4'd12, 1'b0);
		send_item(10'd0, 4'd12, 1'b1);
		send_item(10'd0, 4'd13, 1'b0);
		send_item(10'd0, 4'd14, 1'b0);
		send_item(10'd512, 4'd11, 1'b1);
		finish_phase();

		for (int p = 0; p < PHASES; p++) begin
			program_regs(p);
			stop_at = sent_items + PHASE_ITEMS;
			while (sent_items < stop_at) send_scan();
			finish_phase();
		end

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- line_sensor_pid_steering_core.f -----
sv/lsps_pkg.sv
sv/lsps_queue.sv
sv/lsps_front.sv
sv/lsps_back.sv
sv/line_sensor_pid_steering_core.sv
tb/lsps_steer_checker.sv
tb/tb_line_sensor_pid_steering_core.sv
